>>> hdl/efv_pkg.sv
// shared types, constants and arithmetic helpers for the erfinv unit
`default_nettype none
package efv_pkg;

    localparam logic [31:0] QUIET_BIT  = 32'h0040_0000;
    localparam logic [31:0] DEF_NAN    = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG    = 31'h7F80_0000;
    localparam logic [31:0] ONE_BITS   = 32'h3F80_0000;
    localparam logic [31:0] NEG_ONE    = 32'hBF80_0000;
    localparam logic [31:0] NEG_ZERO   = 32'h8000_0000;
    localparam logic [31:0] NEG_INF    = 32'hFF80_0000;
    localparam logic [31:0] POS_INF    = 32'h7F80_0000;
    localparam logic [31:0] TWO_THIRDS = 32'h3F2A_AAAB;
    localparam logic [31:0] LN2_BITS   = 32'h3F31_7218;
    localparam logic [30:0] SPLIT_MAG  = 31'h40C4_0000;

    localparam logic [31:0] LOG_ODD0  = 32'hBE05_7000;
    localparam logic [31:0] LOG_EVEN0 = 32'h3E10_4000;
    localparam logic [31:0] LOG_ODD1  = 32'hBDF8_CCB4;
    localparam logic [31:0] LOG_EVEN1 = 32'h3E0F_2BA0;
    localparam logic [31:0] LOG_ODD2  = 32'hBE2A_D9B1;
    localparam logic [31:0] LOG_EVEN2 = 32'h3E4C_EC59;
    localparam logic [31:0] LOG_ODD3  = 32'hBE7F_FF01;
    localparam logic [31:0] LOG_C3    = 32'h3EAA_AA7D;
    localparam logic [31:0] LOG_C2    = 32'hBF00_0000;

    localparam logic [31:0] TAIL_COEF [0:8] = '{
        32'h2FA6F5A2, 32'h32FBE4D7, 32'h35A3F289, 32'h37EE53EF, 32'h39CE55C9,
        32'h3B46606F, 32'h3B9E5490, 32'hBE877FB3, 32'h3F570B52
    };
    localparam logic [31:0] MID_COEF [0:9] = '{
        32'h31BAE000, 32'h3419DA2C, 32'h35A4C94E, 32'h33F295DD, 32'hB86B8609,
        32'hB91ADF4D, 32'h3B17B201, 32'h3C3D0F26, 32'hBE6D9577, 32'h3F62DFC4
    };

    // step codes along the chain
    localparam int OP_T   = 0;
    localparam int OP_M   = 1;
    localparam int OP_SQ  = 2;
    localparam int OP_OD1 = 3;
    localparam int OP_EV1 = 4;
    localparam int OP_OD2 = 5;
    localparam int OP_EV2 = 6;
    localparam int OP_OD3 = 7;
    localparam int OP_A1  = 8;
    localparam int OP_A2  = 9;
    localparam int OP_A3  = 10;
    localparam int OP_A4  = 11;
    localparam int OP_LV  = 12;
    localparam int OP_P1  = 13;
    localparam int OP_P9  = 21;
    localparam int OP_FIN = 22;
    localparam int N_OPS  = 23;

    localparam int FMA_LAT  = 4;
    localparam int CELL_LAT = FMA_LAT + 1;
    localparam int TOT_LAT  = N_OPS * CELL_LAT;

    typedef struct packed {
        logic [31:0] arg;
        logic [31:0] m;
        logic [31:0] sq;
        logic [31:0] od;
        logic [31:0] ev;
        logic [31:0] acc;
        logic [31:0] ef;
        logic [31:0] lsv;
        logic [31:0] lv;
        logic [31:0] poly;
        logic        lsp;
        logic        tl;
    } t_ctx;

    typedef struct packed {
        logic [23:0]        sig;
        logic signed [11:0] ex;
    } t_split;

    typedef struct packed {
        logic [31:0] m;
        logic [31:0] ef;
        logic        lsp;
        logic [31:0] lsv;
    } t_lnp;

    function automatic logic is_nan(input logic [31:0] v);
        return v[30:0] > INF_MAG;
    endfunction

    function automatic logic [4:0] lzc24(input logic [23:0] x);
        logic [4:0] c;
        c = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (x[i]) c = 5'(23 - i);
        end
        return c;
    endfunction

    function automatic logic [6:0] lzc64(input logic [63:0] x);
        logic [6:0] c;
        c = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) c = 7'(63 - i);
        end
        return c;
    endfunction

    function automatic logic [63:0] shr_jam(input logic [63:0] v, input logic signed [11:0] n);
        logic [63:0] mask;
        mask = (64'd1 << n[5:0]) - 64'd1;
        if (n <= 0) return v;
        if (n >= 12'sd64) return {63'd0, |v};
        return (v >> n[5:0]) | {63'd0, |(v & mask)};
    endfunction

    function automatic t_split split32(input logic [30:0] m);
        t_split     s;
        logic [4:0] k;
        logic [23:0] f;
        f = {1'b0, m[22:0]};
        k = lzc24(f);
        if (m[30:23] != 8'd0) begin
            s.sig = {1'b1, m[22:0]};
            s.ex  = $signed({4'd0, m[30:23]}) - 12'sd127;
        end else begin
            s.sig = f << k;
            s.ex  = -12'sd126 - $signed({7'd0, k});
        end
        return s;
    endfunction

    // leading one of sig sits at bit 62
    function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] ex,
                                               input logic [63:0] sig);
        logic signed [11:0] sh;
        logic [31:0] base, q, val;
        logic [63:0] rem, half, mask;
        if (ex >= -12'sd126) begin
            sh   = 12'sd39;
            base = {20'd0, 12'(ex + 12'sd126)} << 23;
        end else begin
            sh   = 12'sd39 + (-12'sd126 - ex);
            base = 32'd0;
        end
        mask = (64'd1 << sh[5:0]) - 64'd1;
        half = 64'd1 << (sh[5:0] - 6'd1);
        q    = 32'(sig >> sh[5:0]);
        rem  = sig & mask;
        if (rem > half || (rem == half && q[0])) q = q + 32'd1;
        val = base + q;
        if (ex > 12'sd127) return {sgn, INF_MAG};
        if (sh > 12'sd63) return {sgn, 31'd0};
        if (val >= POS_INF) return {sgn, INF_MAG};
        return {sgn, 31'd0} | val;
    endfunction

    function automatic logic [31:0] int_to_f32(input logic signed [9:0] n);
        logic        sg;
        logic [9:0]  mag;
        logic [3:0]  pos;
        logic [31:0] sh;
        sg  = n[9];
        mag = sg ? 10'(-n) : 10'(n);
        pos = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (mag[i]) pos = 4'(i);
        end
        sh = {22'd0, mag} << (5'd23 - {1'b0, pos});
        if (mag == 10'd0) return 32'd0;
        return {sg, 8'(8'd127 + {4'd0, pos}), sh[22:0]};
    endfunction

    function automatic t_lnp ln_prep(input logic [31:0] t);
        t_lnp              r;
        logic [4:0]        k;
        logic [23:0]       frs;
        logic signed [9:0] expo;
        logic [31:0]       mant;
        k   = lzc24({1'b0, t[22:0]});
        frs = {1'b0, t[22:0]} << k;
        if (t[30:23] != 8'd0) begin
            expo = $signed({2'd0, t[30:23]}) - 10'sd126;
            mant = {9'b001111110, t[22:0]};
        end else begin
            expo = -10'sd125 - $signed({5'd0, k});
            mant = {9'b001111110, frs[22:0]};
        end
        if (mant < TWO_THIRDS) begin
            mant = mant + 32'h0080_0000;
            expo = expo - 10'sd1;
        end
        r.m   = mant;
        r.ef  = int_to_f32(expo);
        r.lsp = 1'b1;
        if (is_nan(t))                r.lsv = t | QUIET_BIT;
        else if (t[30:0] == 31'd0)    r.lsv = NEG_INF;
        else if (t[31])               r.lsv = DEF_NAN;
        else if (t == POS_INF)        r.lsv = POS_INF;
        else begin
            r.lsv = 32'd0;
            r.lsp = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/efv_fma.sv
// four-stage binary32 fused multiply-add, round to nearest even
`default_nettype none
module efv_fma import efv_pkg::*; #(
    parameter int SB_W = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_vld,
    input  wire logic [31:0]     i_a,
    input  wire logic [31:0]     i_b,
    input  wire logic [31:0]     i_c,
    input  wire logic [SB_W-1:0] i_sb,
    output logic                 o_vld,
    output logic [31:0]          o_res,
    output logic [SB_W-1:0]      o_sb
);
    logic [30:0] mu, mv, mw;
    logic        sp, sw;
    logic        n1_spec;
    logic [31:0] n1_sval;
    t_split      su, sv, sx;

    logic               r1_vld, r1_spec, r1_sp, r1_sw, r1_wz;
    logic [31:0]        r1_sval;
    logic [47:0]        r1_prod;
    logic signed [11:0] r1_ep, r1_ew;
    logic [23:0]        r1_gw;
    logic [SB_W-1:0]    r1_sb;

    assign mu = i_a[30:0];
    assign mv = i_b[30:0];
    assign mw = i_c[30:0];
    assign sp = i_a[31] ^ i_b[31];
    assign sw = i_c[31];
    assign su = split32(mu);
    assign sv = split32(mv);
    assign sx = split32(mw);

    always_comb begin
        n1_spec = 1'b1;
        n1_sval = 32'd0;
        if (is_nan(i_a))      n1_sval = i_a | QUIET_BIT;
        else if (is_nan(i_b)) n1_sval = i_b | QUIET_BIT;
        else if (is_nan(i_c)) n1_sval = i_c | QUIET_BIT;
        else if ((mu == INF_MAG && mv == 31'd0) || (mv == INF_MAG && mu == 31'd0))
            n1_sval = DEF_NAN;
        else if (mu == INF_MAG || mv == INF_MAG)
            n1_sval = (mw == INF_MAG && sw != sp) ? DEF_NAN : {sp, INF_MAG};
        else if (mw == INF_MAG) n1_sval = i_c;
        else if (mu == 31'd0 || mv == 31'd0)
            n1_sval = (mw != 31'd0) ? i_c : ((sp == sw) ? {sp, 31'd0} : 32'd0);
        else n1_spec = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else          r1_vld <= i_vld;
        r1_spec <= n1_spec;
        r1_sval <= n1_sval;
        r1_sp   <= sp;
        r1_sw   <= sw;
        r1_wz   <= (mw == 31'd0);
        r1_prod <= su.sig * sv.sig;
        r1_ep   <= su.ex + sv.ex;
        r1_gw   <= sx.sig;
        r1_ew   <= sx.ex;
        r1_sb   <= i_sb;
    end

    // stage 2: align and add
    logic [63:0]        psig, wsig, big, lit, n2_sum;
    logic signed [11:0] ep2, d, ex2;
    logic               bs, ss, n2_sgn, n2_zero;

    logic               r2_vld, r2_spec, r2_sgn;
    logic [31:0]        r2_sval;
    logic [63:0]        r2_sum;
    logic signed [11:0] r2_ex;
    logic [SB_W-1:0]    r2_sb;

    always_comb begin
        if (r1_prod[47]) begin
            psig = {1'b0, r1_prod, 15'd0};
            ep2  = r1_ep + 12'sd1;
        end else begin
            psig = {1'b0, r1_prod[46:0], 16'd0};
            ep2  = r1_ep;
        end
        wsig = {1'b0, r1_gw, 39'd0};
        d    = ep2 - r1_ew;
        if (r1_wz) begin
            big = psig; bs = r1_sp; lit = 64'd0; ss = r1_sp; ex2 = ep2;
        end else if (d >= 0) begin
            big = psig; bs = r1_sp; lit = shr_jam(wsig, d); ss = r1_sw; ex2 = ep2;
        end else begin
            big = wsig; bs = r1_sw; lit = shr_jam(psig, -d); ss = r1_sp; ex2 = r1_ew;
        end
        n2_zero = 1'b0;
        n2_sgn  = bs;
        if (bs == ss) begin
            n2_sum = big + lit;
        end else if (big == lit) begin
            n2_sum  = 64'd0;
            n2_zero = 1'b1;
        end else if (big < lit) begin
            n2_sum = lit - big;
            n2_sgn = ss;
        end else begin
            n2_sum = big - lit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else          r2_vld <= r1_vld;
        r2_spec <= r1_spec | n2_zero;
        r2_sval <= r1_spec ? r1_sval : 32'd0;
        r2_sgn  <= n2_sgn;
        r2_sum  <= n2_sum;
        r2_ex   <= ex2;
        r2_sb   <= r1_sb;
    end

    // stage 3: normalize so the leading one is at bit 62
    logic [6:0]         lz;
    logic [63:0]        n3_sig;
    logic signed [11:0] n3_ex;

    logic               r3_vld, r3_spec, r3_sgn;
    logic [31:0]        r3_sval;
    logic [63:0]        r3_sig;
    logic signed [11:0] r3_ex;
    logic [SB_W-1:0]    r3_sb;

    always_comb begin
        lz = lzc64(r2_sum);
        if (r2_sum[63]) begin
            n3_sig = shr_jam(r2_sum, 12'sd1);
            n3_ex  = r2_ex + 12'sd1;
        end else if (lz == 7'd64) begin
            n3_sig = r2_sum;
            n3_ex  = r2_ex;
        end else begin
            n3_sig = r2_sum << (lz[5:0] - 6'd1);
            n3_ex  = r2_ex - $signed({5'd0, lz}) + 12'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else          r3_vld <= r2_vld;
        r3_spec <= r2_spec;
        r3_sval <= r2_sval;
        r3_sgn  <= r2_sgn;
        r3_sig  <= n3_sig;
        r3_ex   <= n3_ex;
        r3_sb   <= r2_sb;
    end

    // stage 4: round and pack
    logic            r4_vld;
    logic [31:0]     r4_res;
    logic [SB_W-1:0] r4_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_vld <= 1'b0;
        else          r4_vld <= r3_vld;
        r4_res <= r3_spec ? r3_sval : round_pack(r3_sgn, r3_ex, r3_sig);
        r4_sb  <= r3_sb;
    end

    assign o_vld = r4_vld;
    assign o_res = r4_res;
    assign o_sb  = r4_sb;
endmodule
`default_nettype wire

>>> hdl/efv_cell.sv
// one step of the chain: operand select, fused multiply-add, write-back
`default_nettype none
module efv_cell import efv_pkg::*; #(
    parameter int OP = OP_T
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_vld,
    input  wire t_ctx i_ctx,
    output logic      o_vld,
    output t_ctx      o_ctx
);
    localparam int KI = (OP >= OP_P1 && OP <= OP_P9) ? OP - OP_P1 + 1 : 1;

    logic [31:0] a, b, c, res;
    logic [$bits(t_ctx)-1:0] sb_out;
    logic f_vld;
    t_ctx f_ctx, n_ctx, r_ctx;
    t_lnp lnp;
    logic r_vld;

    always_comb begin
        a = i_ctx.poly;
        b = i_ctx.lv;
        c = MID_COEF[KI];
        case (OP) inside
            OP_T:   begin a = i_ctx.arg; c = ONE_BITS;
                        b = is_nan(i_ctx.arg) ? (i_ctx.arg | QUIET_BIT) :
                            (i_ctx.arg[30:0] == 31'd0) ? 32'd0 :
                            {~i_ctx.arg[31], i_ctx.arg[30:0]};
                    end
            OP_M:   begin a = i_ctx.m;   b = ONE_BITS;  c = NEG_ONE;   end
            OP_SQ:  begin a = i_ctx.m;   b = i_ctx.m;   c = NEG_ZERO;  end
            OP_OD1: begin a = LOG_ODD0;  b = i_ctx.sq;  c = LOG_ODD1;  end
            OP_EV1: begin a = LOG_EVEN0; b = i_ctx.sq;  c = LOG_EVEN1; end
            OP_OD2: begin a = i_ctx.od;  b = i_ctx.sq;  c = LOG_ODD2;  end
            OP_EV2: begin a = i_ctx.ev;  b = i_ctx.sq;  c = LOG_EVEN2; end
            OP_OD3: begin a = i_ctx.od;  b = i_ctx.sq;  c = LOG_ODD3;  end
            OP_A1:  begin a = i_ctx.ev;  b = i_ctx.m;   c = i_ctx.od;  end
            OP_A2:  begin a = i_ctx.acc; b = i_ctx.m;   c = LOG_C3;    end
            OP_A3:  begin a = i_ctx.acc; b = i_ctx.m;   c = LOG_C2;    end
            OP_A4:  begin a = i_ctx.acc; b = i_ctx.sq;  c = i_ctx.m;   end
            OP_LV:  begin a = i_ctx.ef;  b = LN2_BITS;  c = i_ctx.acc; end
            [OP_P1:OP_P9]: begin
                        c = i_ctx.tl ? TAIL_COEF[KI-1] : MID_COEF[KI];
                    end
            OP_FIN: begin a = i_ctx.arg; b = i_ctx.poly; c = NEG_ZERO; end
            default: ;
        endcase
    end

    efv_fma #(.SB_W($bits(t_ctx))) u_fma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_vld),
        .i_a     (a),
        .i_b     (b),
        .i_c     (c),
        .i_sb    (i_ctx),
        .o_vld   (f_vld),
        .o_res   (res),
        .o_sb    (sb_out)
    );

    assign f_ctx = t_ctx'(sb_out);
    assign lnp   = ln_prep(res);

    always_comb begin
        n_ctx = f_ctx;
        case (OP) inside
            OP_T: begin
                n_ctx.m   = lnp.m;
                n_ctx.ef  = lnp.ef;
                n_ctx.lsp = lnp.lsp;
                n_ctx.lsv = lnp.lsv;
            end
            OP_M, OP_SQ: begin
                if (OP == OP_M) n_ctx.m = res;
                else            n_ctx.sq = res;
            end
            OP_OD1, OP_OD2, OP_OD3: n_ctx.od = res;
            OP_EV1, OP_EV2:         n_ctx.ev = res;
            OP_A1, OP_A2, OP_A3, OP_A4: n_ctx.acc = res;
            OP_LV: begin
                n_ctx.lv   = f_ctx.lsp ? f_ctx.lsv : res;
                n_ctx.tl   = (n_ctx.lv[30:0] > SPLIT_MAG) && (n_ctx.lv[30:0] <= INF_MAG);
                n_ctx.poly = n_ctx.tl ? TAIL_COEF[0] : MID_COEF[0];
            end
            [OP_P1:OP_P9]: begin
                // tail set has one fewer step: the first one passes through
                if (!(f_ctx.tl && KI == 1)) n_ctx.poly = res;
            end
            OP_FIN: n_ctx.poly = res;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else          r_vld <= f_vld;
        r_ctx <= n_ctx;
    end

    assign o_vld = r_vld;
    assign o_ctx = r_ctx;
endmodule
`default_nettype wire

>>> hdl/inverse_error_function_float32_unit.sv
// top level: single-precision inverse error function as a chain of fma cells
// a word passes through 23 fma cells, 5 register stages each, from an accepted start to o_strobe
// throughput: one word per cycle, busy is never raised
// results appear for one cycle on o_strobe and cannot be stalled
// synchronous active-low reset clears all valid bits, datapath registers are not reset
`default_nettype none
module inverse_error_function_float32_unit import efv_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_arg_bits,
    output logic             o_strobe,
    output logic [31:0]      o_result_bits
);
    t_ctx ctx [0:N_OPS];
    logic vld [0:N_OPS];

    assign busy = 1'b0;

    always_comb begin
        ctx[0]     = '0;
        ctx[0].arg = i_arg_bits;
    end
    assign vld[0] = start;

    for (genvar g = 0; g < N_OPS; g++) begin : g_cell
        efv_cell #(.OP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (vld[g]),
            .i_ctx   (ctx[g]),
            .o_vld   (vld[g+1]),
            .o_ctx   (ctx[g+1])
        );
    end

    assign o_strobe      = vld[N_OPS];
    assign o_result_bits = ctx[N_OPS].poly;

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##TOT_LAT o_strobe) else $error("word lost in chain");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe) else $error("strobe right after reset");

    a_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_arg_bits[30:23] == 8'hFF && i_arg_bits[22:0] != 23'd0) |->
        ##TOT_LAT (o_result_bits[30:22] == 9'h1FF)) else $error("nan not propagated");
endmodule
`default_nettype wire

>>> tb/tb_inverse_error_function_float32_unit.sv
// testbench for the single-precision erfinv unit: bit-exact predictor and scoreboard
`default_nettype none
module tb_inverse_error_function_float32_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import efv_pkg::*;

    localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
    localparam logic [31:0] MAG_MASK  = 32'h7FFF_FFFF;
    localparam int          LATENCY   = 115;
    localparam logic [31:0] TAIL_K [0:8] = '{
        32'h2FA6F5A2, 32'h32FBE4D7, 32'h35A3F289, 32'h37EE53EF, 32'h39CE55C9,
        32'h3B46606F, 32'h3B9E5490, 32'hBE877FB3, 32'h3F570B52
    };
    localparam logic [31:0] MID_K [0:9] = '{
        32'h31BAE000, 32'h3419DA2C, 32'h35A4C94E, 32'h33F295DD, 32'hB86B8609,
        32'hB91ADF4D, 32'h3B17B201, 32'h3C3D0F26, 32'hBE6D9577, 32'h3F62DFC4
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] i_arg_bits = '0;
    logic        busy;
    logic        o_strobe;
    logic [31:0] o_result_bits;
    int          n_fail = 0;
    int          send_idle = 0;

    inverse_error_function_float32_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_arg_bits(i_arg_bits), .o_strobe(o_strobe), .o_result_bits(o_result_bits)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit f_nan(logic [31:0] v);
        return (v & MAG_MASK) > POS_INF;
    endfunction

    function automatic logic [63:0] sticky_shr(logic [63:0] v, int n);
        if (n <= 0) return v;
        if (n >= 64) return {63'd0, v != 0};
        return (v >> n) | {63'd0, (v & ((64'd1 << n) - 64'd1)) != 0};
    endfunction

    function automatic void unpack_sig(logic [31:0] v, output logic [23:0] sig,
                                       output int ex);
        logic [23:0] fr;
        int k;
        fr = {1'b0, v[22:0]};
        k = 0;
        if (v[30:23] != 0) begin
            sig = {1'b1, v[22:0]};
            ex = int'(v[30:23]) - 127;
            return;
        end
        while (!fr[23]) begin
            fr = fr << 1;
            k++;
        end
        sig = fr;
        ex = -126 - k;
    endfunction

    // sig leading one at bit 62
    function automatic logic [31:0] rnd(logic [31:0] sgn, int ex, logic [63:0] sig);
        int sh;
        logic [31:0] base, q, val;
        logic [63:0] rem, half;
        if (ex > 127) return sgn | POS_INF;
        if (ex >= -126) begin
            sh = 39;
            base = 32'(ex + 126) << 23;
        end else begin
            sh = 39 + (-126 - ex);
            base = 0;
        end
        if (sh > 63) return sgn;
        q = 32'(sig >> sh);
        rem = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q++;
        val = base + q;
        if (val >= POS_INF) return sgn | POS_INF;
        return sgn | val;
    endfunction

    function automatic logic [31:0] fused(logic [31:0] u, logic [31:0] v, logic [31:0] w);
        logic [31:0] sp, sw, mu, mv, mw, bs, ss;
        logic [23:0] gu, gv, gw;
        int eu, ev, ew, ep, d, ex;
        logic [63:0] prod, psig, wsig, big, lit, sum;
        sp = (u ^ v) & SIGN_MASK;
        sw = w & SIGN_MASK;
        mu = u & MAG_MASK;
        mv = v & MAG_MASK;
        mw = w & MAG_MASK;
        if (f_nan(u)) return u | QUIET_BIT;
        if (f_nan(v)) return v | QUIET_BIT;
        if (f_nan(w)) return w | QUIET_BIT;
        if ((mu == POS_INF && mv == 0) || (mv == POS_INF && mu == 0)) return DEF_NAN;
        if (mu == POS_INF || mv == POS_INF) begin
            if (mw == POS_INF && sw != sp) return DEF_NAN;
            return sp | POS_INF;
        end
        if (mw == POS_INF) return w;
        if (mu == 0 || mv == 0) begin
            if (mw != 0) return w;
            return (sp == sw) ? sp : 32'd0;
        end
        unpack_sig(mu, gu, eu);
        unpack_sig(mv, gv, ev);
        prod = 64'(gu) * 64'(gv);
        ep = eu + ev;
        if (prod[47]) begin
            psig = prod << 15;
            ep++;
        end else psig = prod << 16;
        if (mw == 0) return rnd(sp, ep, psig);
        unpack_sig(mw, gw, ew);
        wsig = 64'(gw) << 39;
        d = ep - ew;
        if (d >= 0) begin
            big = psig; bs = sp; lit = sticky_shr(wsig, d); ss = sw; ex = ep;
        end else begin
            big = wsig; bs = sw; lit = sticky_shr(psig, -d); ss = sp; ex = ew;
        end
        if (bs == ss) begin
            sum = big + lit;
            if (sum[63]) begin
                sum = sticky_shr(sum, 1);
                ex++;
            end
            return rnd(bs, ex, sum);
        end
        if (big == lit) return 32'd0;
        if (big < lit) begin
            sum = lit - big;
            bs = ss;
        end else sum = big - lit;
        while (!sum[62]) begin
            sum = sum << 1;
            ex--;
        end
        return rnd(bs, ex, sum);
    endfunction

    function automatic logic [31:0] int_float(int n);
        logic [31:0] sg, mg;
        int p;
        sg = 0;
        p = 0;
        if (n == 0) return 0;
        if (n < 0) begin
            sg = SIGN_MASK;
            mg = 32'(-n);
        end else mg = 32'(n);
        while ((mg >> p) > 1) p++;
        return sg | (32'(p + 127) << 23) | ((mg << (23 - p)) & 32'h7F_FFFF);
    endfunction

    function automatic logic [31:0] nat_log(logic [31:0] v);
        logic [31:0] mant, fr, sq, od, ev, acc;
        int expo, k;
        k = 0;
        if (f_nan(v)) return v | QUIET_BIT;
        if ((v & MAG_MASK) == 0) return NEG_INF;
        if (v[31]) return DEF_NAN;
        if (v == POS_INF) return POS_INF;
        if (v[30:23] != 0) begin
            expo = int'(v[30:23]) - 126;
            mant = (v & 32'h7F_FFFF) | 32'h3F00_0000;
        end else begin
            fr = v & 32'h7F_FFFF;
            while (!fr[23]) begin
                fr = fr << 1;
                k++;
            end
            expo = -125 - k;
            mant = 32'h3F00_0000 | (fr & 32'h7F_FFFF);
        end
        if (mant < TWO_THIRDS) begin
            mant += 32'h0080_0000;
            expo--;
        end
        mant = fused(mant, ONE_BITS, NEG_ONE);
        sq = fused(mant, mant, NEG_ZERO);
        od = fused(LOG_ODD0, sq, LOG_ODD1);
        ev = fused(LOG_EVEN0, sq, LOG_EVEN1);
        od = fused(od, sq, LOG_ODD2);
        ev = fused(ev, sq, LOG_EVEN2);
        od = fused(od, sq, LOG_ODD3);
        acc = fused(ev, mant, od);
        acc = fused(acc, mant, LOG_C3);
        acc = fused(acc, mant, LOG_C2);
        acc = fused(acc, sq, mant);
        return fused(int_float(expo), LN2_BITS, acc);
    endfunction

    function automatic logic [31:0] erfinv_of(logic [31:0] a);
        logic [31:0] neg, lv, poly;
        if (f_nan(a)) neg = a | QUIET_BIT;
        else if ((a & MAG_MASK) == 0) neg = 0;
        else neg = a ^ SIGN_MASK;
        lv = nat_log(fused(a, neg, ONE_BITS));
        if ((lv & MAG_MASK) > {1'b0, SPLIT_MAG} && (lv & MAG_MASK) <= POS_INF) begin
            poly = TAIL_K[0];
            for (int k = 1; k < 9; k++) poly = fused(poly, lv, TAIL_K[k]);
        end else begin
            poly = MID_K[0];
            for (int k = 1; k < 10; k++) poly = fused(poly, lv, MID_K[k]);
        end
        return fused(a, poly, NEG_ZERO);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        n_fail++;
    endtask

    class erfinv_scoreboard;
        logic [31:0] pending[$];
        function void note_arg(logic [31:0] a);
            pending.insert(pending.size(), erfinv_of(a));
        endfunction
        task check_word(logic [31:0] got);
            logic [31:0] want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", got));
                return;
            end
            want = pending.pop_front();
            if (got !== want)
                report_mismatch($sformatf("result_bits got %h want %h", got, want));
        endtask
    endclass

    erfinv_scoreboard sb = new();

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) sb.check_word(o_result_bits);
        if (i_rst_n && start && busy === 1'b0) sb.note_arg(i_arg_bits);
    end

    task automatic send_arg(logic [31:0] a);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_arg_bits <= a;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // mostly values inside (-1, 1), with some near one, tiny ones and raw noise
    function automatic logic [31:0] rand_arg();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55) return {1'($urandom), 8'($urandom_range(126, 100)), 23'($urandom)};
        if (sel < 70) return {1'($urandom), 8'd126, 23'($urandom) | 23'h7F_F000};
        if (sel < 80) return {1'($urandom), 8'($urandom_range(99, 0)), 23'($urandom)};
        return $urandom;
    endfunction

    initial begin
        logic [31:0] directed[$];
        directed = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                     32'h3F7F_FFFF, 32'hBF7F_FFFF, 32'h3F00_0000, 32'hBF00_0000,
                     32'h0000_0001, 32'h807F_FFFF, 32'h0080_0000, 32'h3F7F_FFF0,
                     32'h3F80_0001, 32'hC000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h7F7F_FFFF,
                     32'h3DCC_CCCD, 32'h3F73_3333, 32'h3F7F_F000, 32'h5555_5555,
                     32'hAAAA_AAAA};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[i]) send_arg(directed[i]);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = (ph == 1) ? 62 : (ph == 3) ? 20 : 0;
            for (int n = 0; n < 180; n++) send_arg(rand_arg());
            if (ph == 1) begin
                // drain the pipe completely before the next burst
                @(negedge i_clk);
                start <= 1'b0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
        end
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_fail == 0) $display("tb_inverse_error_function_float32_unit: PASS");
        else $display("tb_inverse_error_function_float32_unit: FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("tb_inverse_error_function_float32_unit: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
hdl/efv_pkg.sv
hdl/efv_fma.sv
hdl/efv_cell.sv
hdl/inverse_error_function_float32_unit.sv
tb/tb_inverse_error_function_float32_unit.sv
